// ===== rtl/lpl_pkg.sv =====
package lpl_pkg;

    localparam int MAX_DELAY_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int GAIN_FRAC  = 24;
    localparam int GAIN_W     = 25;
    localparam int MUL_B_W    = 26;
    localparam int THR_W      = 24;
    localparam int ALPHA_W    = 25;
    localparam int DLY_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 25'h1000000;
    localparam logic [THR_W-1:0]   THR_RESET   = 24'd5938679;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 25'd17467;
    localparam logic [DLY_W-1:0]   DLY_RESET   = 10'd960;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_GAIN,
        ST_GAIN_ADD,
        ST_MUL_L,
        ST_MUL_R,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
    } ring_req_t;

endpackage

// ===== rtl/lpl_if.sv =====
interface lpl_sample_if #(
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lpl_result_if #(
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/lpl_div.sv =====
module lpl_div #(
    parameter int PEAK_W = lpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lpl_pkg::THR_W-1:0]      dividend,
    input  logic [PEAK_W-1:0]              divisor,
    output logic                           done,
    output logic [lpl_pkg::GAIN_FRAC-1:0]  quotient
);

    localparam int CNT_W = $clog2(lpl_pkg::GAIN_FRAC);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lpl_pkg::GAIN_FRAC - 1);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [PEAK_W-1:0]             rem_reg;
    logic [PEAK_W-1:0]             divisor_reg;
    logic [lpl_pkg::GAIN_FRAC-1:0] quo_reg;
    logic [PEAK_W:0]               shifted;
    logic [PEAK_W:0]               diff;
    logic                          fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // remainder stays below the divisor, so each step yields one quotient bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= PEAK_W'(dividend);
            divisor_reg <= divisor;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[PEAK_W-1:0] : shifted[PEAK_W-1:0];
            quo_reg <= {quo_reg[lpl_pkg::GAIN_FRAC-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/lpl_mult.sv =====
module lpl_mult #(
    parameter int A_W = lpl_pkg::SAMPLE_BITS_DEF + 2
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [A_W-1:0]                    op_a,
    input  logic signed [lpl_pkg::MUL_B_W-1:0]       op_b,
    output logic signed [A_W+lpl_pkg::MUL_B_W-1:0]   prod
);

    logic signed [A_W+lpl_pkg::MUL_B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/lpl_ring.sv =====
module lpl_ring #(
    parameter int MAX_DELAY   = lpl_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lpl_pkg::ring_req_t           req,
    input  logic [$clog2(MAX_DELAY)-1:0] wr_addr,
    input  logic [2*SAMPLE_BITS-1:0]     wr_data,
    input  logic [$clog2(MAX_DELAY)-1:0] rd_addr,
    output logic [2*SAMPLE_BITS-1:0]     rd_data,
    output logic                         busy
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int DW = 2 * SAMPLE_BITS;
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_DELAY - 1);

    logic [DW-1:0] mem [MAX_DELAY];
    logic [DW-1:0] rd_data_reg;
    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (req.clear)
        begin
            clearing_next = 1'b1;
            clr_cnt_next  = '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == ADDR_LAST)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = AW'(clr_cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// ===== rtl/stereo_lookahead_peak_limiter_top.sv =====
// Stereo lookahead peak limiter.
// Input channel "samples" carries one stereo word (left_sample, right_sample);
// output channel "results" carries one word (left_out, right_out) per input.
// Both use valid/ready; a word moves on a clock edge with both high.
// Configuration: cfg_we, cfg_index, cfg_data write threshold (0), release
// step (1) and lookahead delay (2); other indexes are ignored.
// A word whose peak is at or below the threshold gets unity target gain;
// for a word whose peak exceeds the threshold, one 24-step serial divider
// forms threshold/peak first. The word is stored in the delay line, the gain
// is updated, then the delayed left and right samples are scaled; a single
// registered multiplier is used in turn for the release step and for the
// left and right gain products. One word is processed at a time; the next is
// taken only once the result sits in the output register.
// Reset clears the control state, sets unity gain and the register defaults,
// then sweeps every delay store address to zero with ready low.
// A delay write starts the same sweep and rewinds the write pointer.
// If the receiver stalls, the result holds in the output register and the
// block waits with ready low once its next result is finished.
module stereo_lookahead_peak_limiter_top #(
    parameter int MAX_DELAY   = lpl_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lpl_sample_if.sink                        samples,
    lpl_result_if.source                      results,
    input  logic                              cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW    = $clog2(MAX_DELAY);
    localparam int IDX_W = ((AW > lpl_pkg::DLY_W) ? AW : lpl_pkg::DLY_W) + 1;
    localparam int CMP_W = (SAMPLE_BITS > lpl_pkg::THR_W) ? SAMPLE_BITS : lpl_pkg::THR_W;
    localparam int A_W   = (SAMPLE_BITS > lpl_pkg::ALPHA_W) ? SAMPLE_BITS + 1
                                                            : lpl_pkg::ALPHA_W + 1;
    localparam int P_W   = A_W + lpl_pkg::MUL_B_W;
    localparam int GW    = lpl_pkg::GAIN_W;
    localparam int GF    = lpl_pkg::GAIN_FRAC;

    lpl_pkg::state_t state_reg;
    lpl_pkg::state_t state_next;

    logic [lpl_pkg::THR_W-1:0]   thr_reg;
    logic [lpl_pkg::ALPHA_W-1:0] alpha_reg;
    logic [lpl_pkg::DLY_W-1:0]   delay_reg;
    logic [GW-1:0]               gain_reg;
    logic [GW-1:0]               gain_next;
    logic [AW-1:0]               wp_reg;
    logic                        out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] l_reg;
    logic signed [SAMPLE_BITS-1:0] r_reg;
    logic [GW-1:0]                 target_reg;
    logic [AW-1:0]                 rd_addr_reg;
    logic signed [SAMPLE_BITS-1:0] left_res_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;

    logic                    delay_wr;
    logic                    accept;
    logic                    out_free;
    logic [SAMPLE_BITS-1:0]  mag_l;
    logic [SAMPLE_BITS-1:0]  mag_r;
    logic [SAMPLE_BITS-1:0]  peak;
    logic                    need_div;
    logic                    attack;
    logic [lpl_pkg::ALPHA_W-1:0] alpha_sat;
    logic [AW-1:0]           last_idx;
    logic [AW-1:0]           wp_eff;
    logic [AW-1:0]           rd_idx;

    logic                    div_start;
    logic                    div_done;
    logic [GF-1:0]           div_quo;

    lpl_pkg::ring_req_t      ring_req;
    logic [2*SAMPLE_BITS-1:0] ring_rdata;
    logic                    ring_busy;
    logic signed [SAMPLE_BITS-1:0] rd_left;
    logic signed [SAMPLE_BITS-1:0] rd_right;

    logic                    mul_en;
    logic signed [A_W-1:0]   mul_a;
    logic signed [lpl_pkg::MUL_B_W-1:0] mul_b;
    logic signed [P_W-1:0]   mul_prod;

    assign delay_wr = cfg_we && (cfg_index == lpl_pkg::CFG_DELAY);
    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign mag_l    = l_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(~l_reg + 1'b1) : l_reg;
    assign mag_r    = r_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(~r_reg + 1'b1) : r_reg;
    assign peak     = (mag_l > mag_r) ? mag_l : mag_r;
    assign need_div = CMP_W'(peak) > CMP_W'(thr_reg);
    assign attack   = target_reg < gain_reg;
    assign alpha_sat = (alpha_reg > lpl_pkg::GAIN_ONE) ? lpl_pkg::GAIN_ONE : alpha_reg;

    assign last_idx = (IDX_W'(delay_reg) > IDX_W'(MAX_DELAY - 1)) ? AW'(MAX_DELAY - 1)
                                                                  : AW'(delay_reg);
    assign wp_eff   = (wp_reg > last_idx) ? '0 : wp_reg;
    assign rd_idx   = (wp_eff == last_idx) ? '0 : AW'(wp_eff + 1'b1);

    assign rd_left  = ring_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign rd_right = ring_rdata[SAMPLE_BITS-1:0];

    lpl_div #(
        .PEAK_W   (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (thr_reg),
        .divisor  (peak),
        .done     (div_done),
        .quotient (div_quo)
    );

    lpl_ring #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .wr_addr (wp_eff),
        .wr_data ({l_reg, r_reg}),
        .rd_addr (rd_addr_reg),
        .rd_data (ring_rdata),
        .busy    (ring_busy)
    );

    lpl_mult #(
        .A_W  (A_W)
    ) u_mult (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpl_pkg::ST_CLEAR:
            begin
                if (!ring_busy && !delay_wr)
                begin
                    state_next = lpl_pkg::ST_IDLE;
                end
            end
            lpl_pkg::ST_IDLE:
            begin
                if (delay_wr)
                begin
                    state_next = lpl_pkg::ST_CLEAR;
                end
                else if (accept)
                begin
                    state_next = lpl_pkg::ST_PREP;
                end
            end
            lpl_pkg::ST_PREP:
            begin
                state_next = need_div ? lpl_pkg::ST_DIV : lpl_pkg::ST_GAIN;
            end
            lpl_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = lpl_pkg::ST_GAIN;
                end
            end
            lpl_pkg::ST_GAIN:
            begin
                state_next = attack ? lpl_pkg::ST_MUL_L : lpl_pkg::ST_GAIN_ADD;
            end
            lpl_pkg::ST_GAIN_ADD:
            begin
                state_next = lpl_pkg::ST_MUL_L;
            end
            lpl_pkg::ST_MUL_L:
            begin
                state_next = lpl_pkg::ST_MUL_R;
            end
            lpl_pkg::ST_MUL_R:
            begin
                state_next = lpl_pkg::ST_DONE;
            end
            lpl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lpl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        samples.ready  = 1'b0;
        div_start      = 1'b0;
        ring_req.clear = delay_wr;
        ring_req.wr_en = 1'b0;
        ring_req.rd_en = 1'b0;
        mul_en         = 1'b0;
        mul_a          = signed'(A_W'(alpha_sat));
        mul_b          = signed'(lpl_pkg::MUL_B_W'(target_reg - gain_reg));
        case (state_reg)
            lpl_pkg::ST_IDLE:
            begin
                samples.ready = !delay_wr;
            end
            lpl_pkg::ST_PREP:
            begin
                div_start      = need_div;
                ring_req.wr_en = 1'b1;
            end
            lpl_pkg::ST_GAIN:
            begin
                ring_req.rd_en = 1'b1;
                mul_en         = !attack;
            end
            lpl_pkg::ST_MUL_L:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(rd_left);
                mul_b  = signed'(lpl_pkg::MUL_B_W'(gain_reg));
            end
            lpl_pkg::ST_MUL_R:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(rd_right);
                mul_b  = signed'(lpl_pkg::MUL_B_W'(gain_reg));
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    // attack replaces the gain at once, release adds the scaled step
    always_comb
    begin
        gain_next = gain_reg;
        if ((state_reg == lpl_pkg::ST_GAIN) && attack)
        begin
            gain_next = target_reg;
        end
        else if (state_reg == lpl_pkg::ST_GAIN_ADD)
        begin
            gain_next = GW'(gain_reg + mul_prod[GF +: GW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpl_pkg::ST_CLEAR;
            thr_reg       <= lpl_pkg::THR_RESET;
            alpha_reg     <= lpl_pkg::ALPHA_RESET;
            delay_reg     <= lpl_pkg::DLY_RESET;
            gain_reg      <= lpl_pkg::GAIN_ONE;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gain_reg  <= gain_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lpl_pkg::CFG_THRESHOLD:
                    begin
                        thr_reg <= cfg_data[lpl_pkg::THR_W-1:0];
                    end
                    lpl_pkg::CFG_ALPHA:
                    begin
                        alpha_reg <= cfg_data[lpl_pkg::ALPHA_W-1:0];
                    end
                    lpl_pkg::CFG_DELAY:
                    begin
                        delay_reg <= cfg_data[lpl_pkg::DLY_W-1:0];
                    end
                    default:
                    begin
                        thr_reg <= thr_reg;
                    end
                endcase
            end
            if (delay_wr)
            begin
                wp_reg <= '0;
            end
            else if (state_reg == lpl_pkg::ST_PREP)
            begin
                wp_reg <= rd_idx;
            end
            if ((state_reg == lpl_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            l_reg <= samples.left_sample;
            r_reg <= samples.right_sample;
        end
        if (state_reg == lpl_pkg::ST_PREP)
        begin
            rd_addr_reg <= rd_idx;
            if (!need_div)
            begin
                target_reg <= lpl_pkg::GAIN_ONE;
            end
        end
        if ((state_reg == lpl_pkg::ST_DIV) && div_done)
        begin
            target_reg <= GW'(div_quo);
        end
        if (state_reg == lpl_pkg::ST_MUL_R)
        begin
            left_res_reg <= mul_prod[GF +: SAMPLE_BITS];
        end
        if ((state_reg == lpl_pkg::ST_DONE) && out_free)
        begin
            out_left_reg  <= left_res_reg;
            out_right_reg <= mul_prod[GF +: SAMPLE_BITS];
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.left_out  = out_left_reg;
    assign results.right_out = out_right_reg;

endmodule

// ===== dv/tb_stereo_lookahead_peak_limiter_top.sv =====
module tb_stereo_lookahead_peak_limiter_top;
    import lpl_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RING_MAX = MAX_DELAY_DEF;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t l;
        sample_t r;
    } pair_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        sample_t                left;
        sample_t                right;
        logic                   typed;
        sample_t                want_left;
        sample_t                want_right;
    } dir_row_t;

    localparam dir_row_t DIRECTED [35] = '{
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh7FFFFF, 24'sh800000, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh800000, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd1, -24'sd1, 1'b1, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_DELAY, 25'd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_THRESHOLD, 25'h0800000, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_ALPHA, 25'h1000000, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh7FFFFF, 24'sh800000, 1'b1, 24'sh7FFFFF, 24'sh800000},
        '{ROW_WORD, CFG_SPARE, 25'd0, -24'sd1, 24'sd1, 1'b1, -24'sd1, 24'sd1},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh555555, 24'shAAAAAA, 1'b1, 24'sh555555, 24'shAAAAAA},
        '{ROW_REG, CFG_THRESHOLD, 25'd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd1, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh800000, 24'sh7FFFFF, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd4096, -24'sd4096, 1'b1, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_ALPHA, 25'h1FFFFFF, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_THRESHOLD, 25'h1FFFFFF, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh7FFFFF, 24'sh800000, 1'b1, 24'sh7FFFFF, 24'sh800000},
        '{ROW_REG, CFG_SPARE, 25'd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd123456, -24'sd654321, 1'b1,
          24'sd123456, -24'sd654321},
        '{ROW_REG, CFG_THRESHOLD, 25'd4194304, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_ALPHA, 25'd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_DELAY, 25'd1, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd100, -24'sd100, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh800000, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_ALPHA, 25'd17467, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG, CFG_DELAY, 25'd3, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd2000000, -24'sd3000000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sh800001, 24'sd5, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd3, 24'sd3, 1'b0, 24'sd0, 24'sd0},
        '{ROW_WORD, CFG_SPARE, 25'd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    lpl_sample_if sample_bus ();
    lpl_result_if result_bus ();

    stereo_lookahead_peak_limiter_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (sample_bus),
        .results    (result_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    sample_t            ring_l [RING_MAX];
    sample_t            ring_r [RING_MAX];
    int unsigned        wr_ptr;
    logic [GAIN_W-1:0]  gain_now;
    logic [THR_W-1:0]   thr_now;
    logic [ALPHA_W-1:0] alpha_now;
    logic [DLY_W-1:0]   dly_now;

    pair_t       due_pairs [$];
    int unsigned words_sent;
    int unsigned pairs_checked;
    int unsigned gain_cuts;
    int unsigned reg_writes;
    int unsigned fails;

    function automatic void clear_ring();
        for (int i = 0; i < RING_MAX; i++)
        begin
            ring_l[i] = '0;
            ring_r[i] = '0;
        end
        wr_ptr = 0;
    endfunction

    function automatic pair_t limit_word(input sample_t l, input sample_t r);
        longint      mag_l;
        longint      mag_r;
        longint      peak;
        longint      target;
        longint      gain;
        longint      step;
        int unsigned ring_len;
        int unsigned wp;
        int unsigned rp;
        pair_t       res;
        mag_l = (l < 0) ? -longint'(l) : longint'(l);
        mag_r = (r < 0) ? -longint'(r) : longint'(r);
        peak = (mag_l > mag_r) ? mag_l : mag_r;
        target = longint'(GAIN_ONE);
        if (peak > longint'(thr_now))
        begin
            target = (longint'(thr_now) << GAIN_FRAC) / peak;
            gain_cuts++;
        end
        gain = longint'(gain_now);
        if (target < gain)
        begin
            gain = target;
        end
        else
        begin
            step = (alpha_now > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(alpha_now);
            gain = gain + ((step * (target - gain)) >>> GAIN_FRAC);
        end
        gain_now = gain[GAIN_W-1:0];

        ring_len = (int'(dly_now) > RING_MAX - 1) ? RING_MAX : int'(dly_now) + 1;
        wp = (wr_ptr >= ring_len) ? 0 : wr_ptr;
        ring_l[wp] = l;
        ring_r[wp] = r;
        rp = (wp + 1 >= ring_len) ? 0 : wp + 1;
        wr_ptr = rp;

        res.l = sample_t'((longint'(ring_l[rp]) * gain) >>> GAIN_FRAC);
        res.r = sample_t'((longint'(ring_r[rp]) * gain) >>> GAIN_FRAC);
        return res;
    endfunction

    function automatic sample_t pick_sample(input int unsigned style);
        sample_t s;
        case (style)
            0: s = sample_t'($urandom_range(4194304, 8388607));
            1: s = sample_t'($urandom_range(0, 2047));
            2: s = sample_t'($urandom);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: s = 24'sh7FFFFF;
                    1: s = 24'sh800000;
                    2: s = '0;
                    default: s = -24'sd1;
                endcase
            end
        endcase
        if (style < 2 && $urandom_range(0, 1) == 1)
            s = -s;
        return s;
    endfunction

    // hold the word until the block takes it
    task automatic push_word(input sample_t l, input sample_t r, input logic typed,
                             input sample_t want_l, input sample_t want_r);
        pair_t want;
        sample_bus.valid        <= 1'b1;
        sample_bus.left_sample  <= l;
        sample_bus.right_sample <= r;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        want = limit_word(l, r);
        if (typed)
        begin
            want.l = want_l;
            want.r = want_r;
        end
        due_pairs.push_back(want);
        words_sent++;
    endtask

    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        while (due_pairs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD: thr_now = value[THR_W-1:0];
            CFG_ALPHA:     alpha_now = value[ALPHA_W-1:0];
            CFG_DELAY:
            begin
                dly_now = value[DLY_W-1:0];
                clear_ring();
            end
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic run_words(input int unsigned count);
        int unsigned to_send;
        int unsigned burst;
        int unsigned gap;
        int unsigned pick;
        int unsigned style;
        to_send = count;
        while (to_send > 0)
        begin
            burst = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
            if (burst > to_send)
                burst = to_send;
            pick = $urandom_range(0, 9);
            style = (pick < 4) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_word(pick_sample(style), pick_sample($urandom_range(0, 3)),
                              1'b0, '0, '0);
                else
                    push_word(pick_sample(style), pick_sample(style), 1'b0, '0, '0);
            end
            to_send -= burst;
            if ($urandom_range(0, 19) == 0)
            begin
                wait_drained();
            end
            else
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0)
                begin
                    sample_bus.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin : stall_pattern
        int unsigned hold;
        hold = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    result_bus.ready <= 1'b1;
                    hold = $urandom_range(40, 300);
                end
                else
                begin
                    result_bus.ready <= 1'($urandom_range(0, 1));
                    hold = $urandom_range(1, 12);
                end
            end
            else
            begin
                hold--;
            end
        end
    end

    always @(posedge clk)
    begin : check_out
        pair_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (due_pairs.size() == 0)
            begin
                $error("result word with nothing due: left_out %0d, right_out %0d",
                       result_bus.left_out, result_bus.right_out);
                fails++;
            end
            else
            begin
                want = due_pairs.pop_front();
                if (result_bus.left_out !== want.l)
                begin
                    $error("left_out: expected %0d, got %0d", want.l, result_bus.left_out);
                    fails++;
                end
                if (result_bus.right_out !== want.r)
                begin
                    $error("right_out: expected %0d, got %0d", want.r, result_bus.right_out);
                    fails++;
                end
                pairs_checked++;
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb_stereo_lookahead_peak_limiter_top NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t           row;
        logic [THR_W-1:0]   thr_val;
        logic [ALPHA_W-1:0] alpha_val;
        logic [DLY_W-1:0]   dly_val;

        sample_bus.valid        = 1'b0;
        sample_bus.left_sample  = '0;
        sample_bus.right_sample = '0;
        words_sent    = 0;
        pairs_checked = 0;
        gain_cuts     = 0;
        reg_writes    = 0;
        fails         = 0;
        clear_ring();
        gain_now  = GAIN_ONE;
        thr_now   = THR_RESET;
        alpha_now = ALPHA_RESET;
        dly_now   = DLY_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_REG)
            begin
                wait_drained();
                write_reg(row.reg_index, row.reg_value);
            end
            else
            begin
                push_word(row.left, row.right, row.typed, row.want_left, row.want_right);
            end
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: thr_val = '0;
                1: thr_val = THR_W'($urandom_range(1, 4096));
                2, 3: thr_val = THR_W'($urandom_range(1, 8388608));
                4: thr_val = THR_W'($urandom_range(4194304, 8388608));
                default: thr_val = THR_W'($urandom_range(8388608, 16777215));
            endcase
            case ($urandom_range(0, 5))
                0: alpha_val = '0;
                1, 2: alpha_val = ALPHA_W'($urandom_range(1, 65536));
                3: alpha_val = ALPHA_W'($urandom_range(65536, 16777216));
                4: alpha_val = GAIN_ONE;
                default: alpha_val = ALPHA_W'($urandom_range(16777217, 33554431));
            endcase
            if (ph == 3)
                dly_val = DLY_W'(RING_MAX - 1);
            else if ($urandom_range(0, 3) == 0)
                dly_val = DLY_W'($urandom_range(9, 64));
            else
                dly_val = DLY_W'($urandom_range(0, 8));
            write_reg(CFG_THRESHOLD, {1'($urandom), thr_val});
            write_reg(CFG_ALPHA, alpha_val);
            // in phase 5 keep the ring and the gain running across the phase
            if (ph != 5)
                write_reg(CFG_DELAY, {15'($urandom), dly_val});
            if (ph % 2 == 0)
                write_reg(CFG_SPARE, 25'($urandom));
            run_words((ph == 3) ? 1040 : 60);
        end

        wait_drained();
        repeat (64) @(posedge clk);

        $display("Checked %0d result words against %0d sample words after %0d register writes.",
                 pairs_checked, words_sent, reg_writes);
        $display("%0d words pulled the target gain below unity; delays from 0 to %0d.",
                 gain_cuts, RING_MAX - 1);
        if (fails == 0)
            $display("tb_stereo_lookahead_peak_limiter_top OK");
        else
            $display("tb_stereo_lookahead_peak_limiter_top NOT OK");
        $finish;
    end

endmodule
